>>> sv/pto_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pto_pkg
// shared types, command codes and default sizes for the torque selector
// ----------------------------------------------------------------------------
package pto_pkg;

  localparam int MAX_COMPS_DEF       = 1024;
  localparam int MAX_PINS_DEF        = 4096;
  localparam int MAX_NETS_DEF        = 2048;
  localparam int MAX_NET_ENTRIES_DEF = 4096;
  localparam int COORD_BITS_DEF      = 24;

  localparam int IDX_W    = 12;
  localparam int VAL_W    = 24;
  localparam int FIRST_W  = 12;
  localparam int COUNT_W  = 13;
  localparam int NET_W    = 12;
  localparam int OWNER_W  = 10;
  localparam int NSTART_W = 13;
  localparam int MEMBER_W = 12;
  localparam int MAG_W    = 62;

  localparam logic [3:0]       MASK_RESET = 4'hF;
  localparam logic [MAG_W-1:0] MAG_MAX    = {MAG_W{1'b1}};

  typedef enum logic [2:0] {
    CMD_COMP_POS   = 3'd0,
    CMD_COMP_PINS  = 3'd1,
    CMD_PIN_OFF    = 3'd2,
    CMD_PIN_LINK   = 3'd3,
    CMD_NET_START  = 3'd4,
    CMD_NET_MEMBER = 3'd5,
    CMD_QUERY      = 3'd6
  } cmd_t;

  // one load beat toward the tables
  typedef struct packed {
    logic               en;
    logic [2:0]         command;
    logic [IDX_W-1:0]   index;
    logic [1:0]         orient;
    logic [VAL_W-1:0]   value_a;
    logic [VAL_W-1:0]   value_b;
    logic               no_net;
  } pto_wr_t;

  // read addresses, one per table, registered data back next cycle
  typedef struct packed {
    logic [15:0] comp_addr;
    logic [1:0]  pin_orient;
    logic [15:0] pin_idx;
    logic [15:0] link_addr;
    logic [16:0] ns_addr;
    logic [15:0] mem_addr;
  } pto_rd_t;

endpackage
`default_nettype wire

>>> sv/pto_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pto_in_if
// command channel: loads and queries
// ----------------------------------------------------------------------------
interface pto_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [11:0]        index;
  logic [1:0]         orient;
  logic signed [23:0] value_a;
  logic signed [23:0] value_b;
  logic               no_net;

  modport source (output valid, command, index, orient, value_a, value_b, no_net,
                  input ready);
  modport sink (input valid, command, index, orient, value_a, value_b, no_net,
                output ready);
endinterface
`default_nettype wire

>>> sv/pto_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pto_out_if
// result channel: chosen orientation and torque magnitude
// ----------------------------------------------------------------------------
interface pto_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  best_orient;
  logic [61:0] torque_magnitude;

  modport source (output valid, best_orient, torque_magnitude, input ready);
  modport sink (input valid, best_orient, torque_magnitude, output ready);
endinterface
`default_nettype wire

>>> sv/pin_torque_orientation_select_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pin_torque_orientation_select_core
// picks the component orientation with the least net pin torque
// ----------------------------------------------------------------------------
// in_ch carries load beats (component position and pin range, pin offsets per
// orientation, pin links, net starts and net members) and query beats. A load
// beat is taken when idle and writes the tables; it gives no result.
// A query beat names a component. The sequencer tries the stored orientation
// first and then every other orientation enabled in cfg_wdata's mask, walking
// each pin of the part and every member of that pin's net through the tables.
// One beat on out_ch carries the winning orientation and |torque|.
// in_ch.ready is low for the whole query. The result sits in an output
// register; if out_ch stalls the block still takes loads, and a second query
// waits at its end until the held beat is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle, drops
// out_ch.valid and sets the orientation mask to all four. Tables are not
// cleared; an entry must be loaded before a query reads it.
// ----------------------------------------------------------------------------
module pin_torque_orientation_select_core #(
  parameter int MAX_COMPS       = pto_pkg::MAX_COMPS_DEF,
  parameter int MAX_PINS        = pto_pkg::MAX_PINS_DEF,
  parameter int MAX_NETS        = pto_pkg::MAX_NETS_DEF,
  parameter int MAX_NET_ENTRIES = pto_pkg::MAX_NET_ENTRIES_DEF,
  parameter int COORD_BITS      = pto_pkg::COORD_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  pto_in_if.sink          in_ch,
  pto_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata
);
  import pto_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int SUM_W = CW + 14;   // member sums: up to 2^13 coordinate pairs
  localparam int PW    = 2 * CW + 2;
  localparam int TW    = 2 * CW + 3;
  localparam int P_W   = 14;        // pin walk reaches first + count
  localparam logic [16:0] COMPS_L   = 17'(MAX_COMPS);
  localparam logic [16:0] PINS_L    = 17'(MAX_PINS);
  localparam logic [16:0] NETS_L    = 17'(MAX_NETS);
  localparam logic [16:0] ENTRIES_L = 17'(MAX_NET_ENTRIES);
  localparam logic [COUNT_W-1:0] MIN_PINS = COUNT_W'(3);
  localparam logic [P_W-1:0]     MIN_NET  = P_W'(2);

  typedef enum logic [4:0] {
    S_IDLE, S_CMP, S_OSTART, S_PIN, S_LINK, S_NS0, S_NS1, S_OFF,
    S_MEM, S_MQ, S_QL, S_QC, S_QO, S_CEN, S_DX, S_DY,
    S_M1, S_M2, S_M3, S_OEND, S_OUT
  } state_t;

  state_t state_r;

  // result register
  logic              out_valid_r;
  logic [1:0]        out_orient_r;
  logic [MAG_W-1:0]  out_mag_r;
  logic [3:0]        mask_r;

  // query context
  logic signed [CW-1:0]    cx_r, cy_r;
  logic [1:0]              orient_r;
  logic [3:0]              left_r;
  logic                    first_r;
  logic [FIRST_W-1:0]      begin_r;
  logic [COUNT_W-1:0]      count_r;
  logic [P_W-1:0]          p_end_r;
  logic [P_W-1:0]          p_r;
  logic [NET_W-1:0]        net_r;
  logic [NSTART_W-1:0]     nb_r, ne_r, e_r;
  logic [MEMBER_W-1:0]     q_r;
  logic signed [CW-1:0]    rx_r, ry_r, ox_r, oy_r;
  logic signed [CW:0]      px_r, py_r, cxq_r, cyq_r;
  logic signed [SUM_W-1:0] tx_r, ty_r;
  logic [COUNT_W-1:0]      others_r;
  logic signed [PW-1:0]    p1_r;
  logic signed [63:0]      torque_r;
  logic [MAG_W-1:0]        best_r;
  logic [1:0]              best_o_r;

  // table signals
  pto_wr_t                 wr;
  pto_rd_t                 rd;
  logic signed [CW-1:0]    t_cx, t_cy, t_dx, t_dy;
  logic [1:0]              t_corient;
  logic [FIRST_W-1:0]      t_first;
  logic [COUNT_W-1:0]      t_count;
  logic [NET_W-1:0]        t_net;
  logic [OWNER_W-1:0]      t_owner;
  logic                    t_nonet;
  logic [NSTART_W-1:0]     t_ns;
  logic [MEMBER_W-1:0]     t_member;

  // shared arithmetic
  logic                    div_start, div_done;
  logic signed [SUM_W-1:0] div_q;
  logic signed [CW-1:0]    mul_a;
  logic signed [CW+1:0]    mul_b;
  logic signed [PW-1:0]    mul_p;

  logic                    in_acc;
  logic signed [TW-1:0]    term;
  logic signed [64:0]      tsum;
  logic [63:0]             tabs;
  logic [MAG_W-1:0]        tmag;
  logic                    have_next;
  logic [1:0]              next_o;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign wr = '{en: in_acc, command: in_ch.command, index: in_ch.index,
                orient: in_ch.orient, value_a: in_ch.value_a,
                value_b: in_ch.value_b, no_net: in_ch.no_net};

  // read address for the data the next state consumes
  always_comb begin
    rd = '0;
    unique case (state_r)
      S_IDLE: rd.comp_addr = 16'(in_ch.index);
      S_PIN:  rd.link_addr = 16'(p_r);
      S_LINK: rd.ns_addr   = 17'(t_net);
      S_NS0:  rd.ns_addr   = 17'(net_r) + 17'd1;
      S_NS1: begin
        rd.pin_orient = orient_r;
        rd.pin_idx    = 16'(p_r);
      end
      S_MEM:  rd.mem_addr  = 16'(e_r);
      S_MQ:   rd.link_addr = 16'(t_member);
      S_QL:   rd.comp_addr = 16'(t_owner);
      S_QC: begin
        rd.pin_orient = t_corient;
        rd.pin_idx    = 16'(q_r);
      end
      default: ;
    endcase
  end

  pto_tables #(
    .MAX_COMPS(MAX_COMPS), .MAX_PINS(MAX_PINS), .MAX_NETS(MAX_NETS),
    .MAX_NET_ENTRIES(MAX_NET_ENTRIES), .COORD_BITS(COORD_BITS)
  ) u_tables (
    .clk(clk), .wr(wr), .rd(rd),
    .comp_x(t_cx), .comp_y(t_cy), .comp_orient(t_corient),
    .comp_first(t_first), .comp_count(t_count),
    .pin_dx(t_dx), .pin_dy(t_dy),
    .link_net(t_net), .link_comp(t_owner), .link_nonet(t_nonet),
    .ns_data(t_ns), .mem_data(t_member)
  );

  // centroid divisions: x from the member count check, y once x is back
  assign div_start = (state_r == S_CEN && others_r != '0) || (state_r == S_DX && div_done);

  pto_div #(.SUM_W(SUM_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend((state_r == S_CEN) ? tx_r : ty_r), .divisor(others_r),
    .done(div_done), .quotient(div_q)
  );

  // rx * (cy - py) issued in S_M1, ry * (cx - px) in S_M2
  always_comb begin
    if (state_r == S_M2) begin
      mul_a = ry_r;
      mul_b = (CW+2)'(cxq_r) - (CW+2)'(px_r);
    end else begin
      mul_a = rx_r;
      mul_b = (CW+2)'(cyq_r) - (CW+2)'(py_r);
    end
  end

  pto_mul #(.COORD_BITS(COORD_BITS)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(mul_p));

  // pin term and saturating accumulate
  assign term = TW'(p1_r) - TW'(mul_p);
  assign tsum = 65'(torque_r) + 65'(term);

  // magnitude of the finished orientation, clamped to 62 bits
  assign tabs = torque_r[63] ? 64'(0) - 64'(torque_r) : 64'(torque_r);
  assign tmag = (tabs > 64'(MAG_MAX)) ? MAG_MAX : tabs[MAG_W-1:0];

  // next enabled orientation, lowest first
  always_comb begin
    have_next = 1'b0;
    next_o    = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (left_r[i]) begin
        have_next = 1'b1;
        next_o    = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mask_r      <= MASK_RESET;
    end else begin
      if (cfg_we) mask_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.command == CMD_QUERY && 17'(in_ch.index) < COMPS_L) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          cx_r     <= t_cx;
          cy_r     <= t_cy;
          orient_r <= t_corient;
          begin_r  <= t_first;
          count_r  <= t_count;
          p_end_r  <= P_W'(t_first) + P_W'(t_count);
          left_r   <= mask_r & ~(4'b0001 << t_corient);
          first_r  <= 1'b1;
          state_r  <= S_OSTART;
        end
        S_OSTART: begin
          torque_r <= '0;
          p_r      <= P_W'(begin_r);
          state_r  <= (count_r < MIN_PINS) ? S_OEND : S_PIN;
        end
        S_PIN: begin
          if (p_r >= p_end_r) begin
            state_r <= S_OEND;
          end else if (17'(p_r) >= PINS_L) begin
            p_r <= p_r + P_W'(1);
          end else begin
            state_r <= S_LINK;
          end
        end
        S_LINK: begin
          net_r <= t_net;
          if (t_nonet || 17'(t_net) >= NETS_L) begin
            p_r     <= p_r + P_W'(1);
            state_r <= S_PIN;
          end else begin
            state_r <= S_NS0;
          end
        end
        S_NS0: begin
          nb_r    <= t_ns;
          state_r <= S_NS1;
        end
        S_NS1: begin
          ne_r <= t_ns;
          if (P_W'(t_ns) < P_W'(nb_r) + MIN_NET) begin
            p_r     <= p_r + P_W'(1);
            state_r <= S_PIN;
          end else begin
            state_r <= S_OFF;
          end
        end
        S_OFF: begin
          rx_r     <= t_dx;
          ry_r     <= t_dy;
          px_r     <= (CW+1)'(cx_r) + (CW+1)'(t_dx);
          py_r     <= (CW+1)'(cy_r) + (CW+1)'(t_dy);
          e_r      <= nb_r;
          tx_r     <= '0;
          ty_r     <= '0;
          others_r <= '0;
          state_r  <= S_MEM;
        end
        S_MEM: begin
          if (e_r >= ne_r) begin
            state_r <= S_CEN;
          end else if (17'(e_r) >= ENTRIES_L) begin
            e_r <= e_r + NSTART_W'(1);
          end else begin
            state_r <= S_MQ;
          end
        end
        S_MQ: begin
          q_r <= t_member;
          // the pin itself and pins beyond the table are not members
          if (P_W'(t_member) == p_r || 17'(t_member) >= PINS_L) begin
            e_r     <= e_r + NSTART_W'(1);
            state_r <= S_MEM;
          end else begin
            state_r <= S_QL;
          end
        end
        S_QL: begin
          if (17'(t_owner) >= COMPS_L) begin
            e_r     <= e_r + NSTART_W'(1);
            state_r <= S_MEM;
          end else begin
            state_r <= S_QC;
          end
        end
        S_QC: begin
          ox_r    <= t_cx;
          oy_r    <= t_cy;
          state_r <= S_QO;
        end
        S_QO: begin
          tx_r     <= tx_r + SUM_W'(ox_r) + SUM_W'(t_dx);
          ty_r     <= ty_r + SUM_W'(oy_r) + SUM_W'(t_dy);
          others_r <= others_r + COUNT_W'(1);
          e_r      <= e_r + NSTART_W'(1);
          state_r  <= S_MEM;
        end
        S_CEN: begin
          if (others_r == '0) begin
            p_r     <= p_r + P_W'(1);
            state_r <= S_PIN;
          end else begin
            state_r <= S_DX;
          end
        end
        S_DX: begin
          if (div_done) begin
            cxq_r   <= (CW+1)'(div_q);
            state_r <= S_DY;
          end
        end
        S_DY: begin
          if (div_done) begin
            cyq_r   <= (CW+1)'(div_q);
            state_r <= S_M1;
          end
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          p1_r    <= mul_p;
          state_r <= S_M3;
        end
        S_M3: begin
          if (tsum[64] != tsum[63]) begin
            torque_r <= tsum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          end else begin
            torque_r <= tsum[63:0];
          end
          p_r     <= p_r + P_W'(1);
          state_r <= S_PIN;
        end
        S_OEND: begin
          // strictly smaller wins, so a tie keeps the orientation tried first
          if (first_r || tmag < best_r) begin
            best_r   <= tmag;
            best_o_r <= orient_r;
          end
          first_r <= 1'b0;
          if (have_next) begin
            orient_r        <= next_o;
            left_r[next_o]  <= 1'b0;
            state_r         <= S_OSTART;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_orient_r <= best_o_r;
            out_mag_r    <= best_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.best_orient      = out_orient_r;
  assign out_ch.torque_magnitude = out_mag_r;

  a_result_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside the output state");

  a_held_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && !out_ch.ready) |=> state_r == S_OUT)
    else $error("pending result overwritten");

  a_pin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |-> (17'(p_r) < PINS_L && p_r < p_end_r))
    else $error("pin walk outside the part");

  a_div_only_centroid: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DX || state_r == S_DY))
    else $error("divider result with no consumer");

endmodule
`default_nettype wire

>>> sv/pto_tables.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pto_tables
// placement memories, one write port from loads, one registered read each
// ----------------------------------------------------------------------------
module pto_tables #(
  parameter int MAX_COMPS       = pto_pkg::MAX_COMPS_DEF,
  parameter int MAX_PINS        = pto_pkg::MAX_PINS_DEF,
  parameter int MAX_NETS        = pto_pkg::MAX_NETS_DEF,
  parameter int MAX_NET_ENTRIES = pto_pkg::MAX_NET_ENTRIES_DEF,
  parameter int COORD_BITS      = pto_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire pto_pkg::pto_wr_t                     wr,
  input  wire pto_pkg::pto_rd_t                     rd,
  output logic signed [COORD_BITS-1:0]              comp_x,
  output logic signed [COORD_BITS-1:0]              comp_y,
  output logic [1:0]                                comp_orient,
  output logic [pto_pkg::FIRST_W-1:0]               comp_first,
  output logic [pto_pkg::COUNT_W-1:0]               comp_count,
  output logic signed [COORD_BITS-1:0]              pin_dx,
  output logic signed [COORD_BITS-1:0]              pin_dy,
  output logic [pto_pkg::NET_W-1:0]                 link_net,
  output logic [pto_pkg::OWNER_W-1:0]               link_comp,
  output logic                                      link_nonet,
  output logic [pto_pkg::NSTART_W-1:0]              ns_data,
  output logic [pto_pkg::MEMBER_W-1:0]              mem_data
);
  import pto_pkg::*;

  localparam int COMP_AW = (MAX_COMPS > 1) ? $clog2(MAX_COMPS) : 1;
  localparam int PIN_AW  = $clog2(MAX_PINS);
  localparam int POFF_AW = $clog2(4 * MAX_PINS);
  localparam int NS_AW   = $clog2(MAX_NETS + 1);
  localparam int MEM_AW  = $clog2(MAX_NET_ENTRIES);
  localparam logic [16:0] COMPS_L   = 17'(MAX_COMPS);
  localparam logic [16:0] PINS_L    = 17'(MAX_PINS);
  localparam logic [16:0] NETS_L    = 17'(MAX_NETS);
  localparam logic [16:0] ENTRIES_L = 17'(MAX_NET_ENTRIES);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [1:0]                   orient;
  } pos_t;

  typedef struct packed {
    logic [FIRST_W-1:0] first;
    logic [COUNT_W-1:0] count;
  } range_t;

  typedef struct packed {
    logic [NET_W-1:0]   net;
    logic [OWNER_W-1:0] owner;
    logic               nonet;
  } link_t;

  pos_t                         pos_mem   [MAX_COMPS];
  range_t                       range_mem [MAX_COMPS];
  logic signed [COORD_BITS-1:0] dx_mem    [4*MAX_PINS];
  logic signed [COORD_BITS-1:0] dy_mem    [4*MAX_PINS];
  link_t                        link_mem  [MAX_PINS];
  logic [NSTART_W-1:0]          ns_mem    [MAX_NETS+1];
  logic [MEMBER_W-1:0]          member_mem[MAX_NET_ENTRIES];

  logic [16:0]        widx;
  logic [POFF_AW-1:0] woff;
  logic [POFF_AW-1:0] roff;
  pos_t               pos_q;
  range_t             range_q;
  link_t              link_q;

  assign widx = 17'(wr.index);
  assign woff = POFF_AW'(wr.orient) * POFF_AW'(MAX_PINS) + POFF_AW'(wr.index);
  assign roff = POFF_AW'(rd.pin_orient) * POFF_AW'(MAX_PINS) + POFF_AW'(rd.pin_idx);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      unique case (wr.command)
        CMD_COMP_POS: begin
          if (widx < COMPS_L) begin
            pos_mem[COMP_AW'(wr.index)] <= '{x: COORD_BITS'($signed(wr.value_a)),
                                             y: COORD_BITS'($signed(wr.value_b)),
                                             orient: wr.orient};
          end
        end
        CMD_COMP_PINS: begin
          if (widx < COMPS_L) begin
            range_mem[COMP_AW'(wr.index)] <= '{first: wr.value_a[FIRST_W-1:0],
                                               count: wr.value_b[COUNT_W-1:0]};
          end
        end
        CMD_PIN_OFF: begin
          if (widx < PINS_L) begin
            dx_mem[woff] <= COORD_BITS'($signed(wr.value_a));
            dy_mem[woff] <= COORD_BITS'($signed(wr.value_b));
          end
        end
        CMD_PIN_LINK: begin
          if (widx < PINS_L) begin
            link_mem[PIN_AW'(wr.index)] <= '{net: wr.value_a[NET_W-1:0],
                                             owner: wr.value_b[OWNER_W-1:0],
                                             nonet: wr.no_net};
          end
        end
        CMD_NET_START: begin
          if (widx <= NETS_L) begin
            ns_mem[NS_AW'(wr.index)] <= wr.value_a[NSTART_W-1:0];
          end
        end
        CMD_NET_MEMBER: begin
          if (widx < ENTRIES_L) begin
            member_mem[MEM_AW'(wr.index)] <= wr.value_a[MEMBER_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pos_q    <= pos_mem[COMP_AW'(rd.comp_addr)];
    range_q  <= range_mem[COMP_AW'(rd.comp_addr)];
    pin_dx   <= dx_mem[roff];
    pin_dy   <= dy_mem[roff];
    link_q   <= link_mem[PIN_AW'(rd.link_addr)];
    ns_data  <= ns_mem[NS_AW'(rd.ns_addr)];
    mem_data <= member_mem[MEM_AW'(rd.mem_addr)];
  end

  assign comp_x      = pos_q.x;
  assign comp_y      = pos_q.y;
  assign comp_orient = pos_q.orient;
  assign comp_first  = range_q.first;
  assign comp_count  = range_q.count;
  assign link_net    = link_q.net;
  assign link_comp   = link_q.owner;
  assign link_nonet  = link_q.nonet;

endmodule
`default_nettype wire

>>> sv/pto_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pto_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module pto_div #(
  parameter int SUM_W = pto_pkg::COORD_BITS_DEF + 14
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic signed [SUM_W-1:0]         dividend,
  input  wire logic [pto_pkg::COUNT_W-1:0]     divisor,
  output logic                                 done,
  output logic signed [SUM_W-1:0]              quotient
);
  import pto_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic               busy_r;
  logic               done_r;
  logic               neg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   mag_r;
  logic [COUNT_W-1:0] rem_r;
  logic [COUNT_W-1:0] dvs_r;
  logic [COUNT_W:0]   rem_sh;
  logic               ge;

  assign rem_sh = {rem_r, mag_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        neg_r  <= dividend[SUM_W-1];
        mag_r  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
        dvs_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(SUM_W);
      end else if (busy_r) begin
        rem_r <= ge ? COUNT_W'(rem_sh - {1'b0, dvs_r}) : COUNT_W'(rem_sh);
        mag_r <= {mag_r[SUM_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(mag_r) : $signed(mag_r);

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");

endmodule
`default_nettype wire

>>> sv/pto_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pto_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
module pto_mul #(
  parameter int COORD_BITS = pto_pkg::COORD_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic signed [COORD_BITS-1:0]     a,
  input  wire logic signed [COORD_BITS+1:0]     b,
  output logic signed [2*COORD_BITS+1:0]        prod
);
  localparam int PW = 2 * COORD_BITS + 2;

  always_ff @(posedge clk) begin
    prod <= PW'(a) * PW'(b);
  end

endmodule
`default_nettype wire
